[hdl/ahx_pkg.sv]
// Package for the Ascon hash/XOF engine: constants, codes and the round function.
`timescale 1ns / 1ps
`default_nettype none
package ahx_pkg;

  localparam int unsigned MaxOutWords    = 64;
  localparam int unsigned MaxCustomBytes = 256;
  localparam int unsigned NumRounds      = 12;

  localparam logic [1:0] ModeHash = 2'd0;
  localparam logic [1:0] ModeXof  = 2'd1;
  localparam logic [1:0] ModeCxof = 2'd2;

  localparam logic [1:0] RegMode      = 2'd0;
  localparam logic [1:0] RegOutWords  = 2'd1;
  localparam logic [1:0] RegCustomLen = 2'd2;

  localparam logic [63:0] IvHash = 64'h0000080100cc0002;
  localparam logic [63:0] IvXof  = 64'h0000080000cc0003;
  localparam logic [63:0] IvCxof = 64'h0000080000cc0004;

  typedef logic [319:0] state_t;

  // One Ascon round; round index 0..11.
  function automatic state_t ascon_round(state_t s, logic [3:0] rnd);
    logic [63:0] w [5];
    logic [63:0] t [5];
    logic [7:0]  rc;
    state_t      r;
    for (int k = 0; k < 5; k++) w[k] = s[64*k +: 64];
    rc = 8'hf0 - {rnd, 4'h0} + {4'h0, rnd};
    w[2] ^= {56'd0, rc};
    w[0] ^= w[4];
    w[4] ^= w[3];
    w[2] ^= w[1];
    for (int k = 0; k < 5; k++) t[k] = ~w[k] & w[(k + 1) % 5];
    for (int k = 0; k < 5; k++) w[k] ^= t[(k + 1) % 5];
    w[1] ^= w[0];
    w[0] ^= w[4];
    w[3] ^= w[2];
    w[2] = ~w[2];
    w[0] ^= {w[0][18:0], w[0][63:19]} ^ {w[0][27:0], w[0][63:28]};
    w[1] ^= {w[1][60:0], w[1][63:61]} ^ {w[1][38:0], w[1][63:39]};
    w[2] ^= {w[2][0],    w[2][63:1]}  ^ {w[2][5:0],  w[2][63:6]};
    w[3] ^= {w[3][9:0],  w[3][63:10]} ^ {w[3][16:0], w[3][63:17]};
    w[4] ^= {w[4][6:0],  w[4][63:7]}  ^ {w[4][40:0], w[4][63:41]};
    for (int k = 0; k < 5; k++) r[64*k +: 64] = w[k];
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/ahx_perm.sv]
// Iterative Ascon permutation: one round per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ahx_perm (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  ahx_pkg::state_t state_i,
  output ahx_pkg::state_t state_o,
  output logic            busy_o,
  output logic            done_o
);

  ahx_pkg::state_t s_q;
  logic [3:0]      rnd_q;
  logic            busy_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 4'(ahx_pkg::NumRounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        rnd_q <= rnd_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) s_q <= state_i;
    else if (busy_q)        s_q <= ahx_pkg::ascon_round(s_q, rnd_q);
  end

  assign state_o = s_q;
  assign busy_o  = busy_q;
  assign done_o  = done_q;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && busy_q)) else $error("done while busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rnd_q < 4'(ahx_pkg::NumRounds)) else $error("round overflow");
`endif

endmodule
`default_nettype wire

[hdl/ascon_hash_xof_engine_unit.sv]
// Top level of the Ascon Hash256 / XOF128 / CXOF128 sponge engine.
//
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | data_word_i, valid_bytes_i,
//         |           |                        | last_word_i, is_custom_i
// out     | output    | out_valid_o / out_stall_i | digest_word_o, last_out_o
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A permutation runs as launch, twelve rounds, capture, next step. A plain message
// word takes one permutation before the input is free; a new run adds one for the
// IV, and the CXOF length, the pad block of a full last word and the bare pad that
// closes an open customization add one each. The first squeeze word comes from the
// permutation of a short last word, each later one from a further permutation after
// the previous transfer, plus receiver stalls. Reset restores register defaults and
// the idle phase; in_stall_o is high until every transfer of the current item ends.
`timescale 1ns / 1ps
`default_nettype none
module ascon_hash_xof_engine_unit #(
  parameter int unsigned MAX_OUT_WORDS    = ahx_pkg::MaxOutWords,
  parameter int unsigned MAX_CUSTOM_BYTES = ahx_pkg::MaxCustomBytes
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [8:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [63:0] data_word_i,
  input  wire  [3:0]  valid_bytes_i,
  input  wire         last_word_i,
  input  wire         is_custom_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] digest_word_o,
  output logic        last_out_o
);

  typedef enum logic [2:0] {
    StIdle, StPerm, StNext, StEmit
  } st_e;

  // Pending absorb or squeeze steps after the current permutation.
  typedef enum logic [2:0] {
    NxDone, NxLen, NxPadThenMsg, NxMsg, NxPad, NxSqueeze
  } nx_e;

  // Phase of the current run.
  typedef enum logic [1:0] {
    PhIdle, PhCustom, PhMsg
  } ph_e;

  localparam int unsigned CntW = $clog2(MAX_OUT_WORDS + 1);

  st_e              st_q;
  nx_e              nx_q;
  logic [1:0]       mode_q;
  logic [6:0]       outw_q;
  logic [8:0]       clen_q;
  ph_e              phase_q;
  logic [63:0]      word_q;
  logic             last_q;
  logic             fin_q;   // item ends the message
  logic [3:0]       valid_q;
  logic             cust_q;
  logic [CntW-1:0]  left_q;
  ahx_pkg::state_t  st_in;
  logic             p_start, p_busy, p_done;
  ahx_pkg::state_t  p_state;
  ahx_pkg::state_t  hold_q;
  logic [63:0]      dig_q;
  logic             lo_q;

  ahx_perm u_perm (
    .clk_i, .rst_ni, .start_i(p_start), .state_i(st_in),
    .state_o(p_state), .busy_o(p_busy), .done_o(p_done)
  );

  // Pad a last word with 0x01 after its valid bytes.
  function automatic logic [63:0] pad_word(logic [63:0] w, logic [3:0] nb);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++)
      if (b < nb) r[8*b +: 8] = w[8*b +: 8];
    if (nb < 4'd8) r[{nb[2:0], 3'b000}] = 1'b1;
    return r;
  endfunction

  logic [CntW-1:0] nout;
  always_comb begin
    if (outw_q == 7'd0) nout = CntW'(1);
    else if (32'(outw_q) > MAX_OUT_WORDS) nout = CntW'(MAX_OUT_WORDS);
    else nout = CntW'(outw_q);
  end

  logic [8:0] clen_sat;
  assign clen_sat = (32'(clen_q) > MAX_CUSTOM_BYTES) ? 9'(MAX_CUSTOM_BYTES) : clen_q;

  logic [63:0] ld_word_q; // word xored before the next permutation
  logic        start_q;

  assign p_start = start_q;
  assign st_in   = {hold_q[319:64], hold_q[63:0] ^ ld_word_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      nx_q      <= NxDone;
      mode_q    <= ahx_pkg::ModeHash;
      outw_q    <= 7'd4;
      clen_q    <= '0;
      phase_q   <= PhIdle;
      start_q   <= 1'b0;
      left_q    <= '0;
      hold_q    <= '0;
      word_q    <= '0;
      last_q    <= 1'b0;
      fin_q     <= 1'b0;
      valid_q   <= '0;
      cust_q    <= 1'b0;
      ld_word_q <= '0;
      dig_q     <= '0;
      lo_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ahx_pkg::RegMode:      mode_q <= cfg_data_i[1:0];
          ahx_pkg::RegOutWords:  outw_q <= cfg_data_i[6:0];
          ahx_pkg::RegCustomLen: clen_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: begin
          start_q <= in_valid_i && (phase_q == PhIdle);
          if (in_valid_i) begin
            word_q <= data_word_i;
            last_q <= last_word_i;
            fin_q  <= last_word_i;
            if (phase_q == PhIdle) begin
              hold_q <= {256'd0, (mode_q == ahx_pkg::ModeHash) ? ahx_pkg::IvHash :
                         (mode_q == ahx_pkg::ModeCxof) ? ahx_pkg::IvCxof : ahx_pkg::IvXof};
              ld_word_q <= '0;
              st_q <= StPerm;
              if (mode_q == ahx_pkg::ModeCxof) begin
                nx_q <= NxLen;
                phase_q <= PhCustom;
              end else begin
                nx_q <= NxMsg;
                phase_q <= PhMsg;
              end
            end else begin
              st_q <= StNext;
              // A customization word counts only while the customization is open.
              nx_q <= (phase_q == PhCustom && !is_custom_i) ? NxPadThenMsg : NxMsg;
            end
            // valid_bytes saturated at 8 and ignored when not last.
            if (!last_word_i || valid_bytes_i > 4'd8) valid_q <= 4'd8;
            else valid_q <= valid_bytes_i;
            cust_q <= is_custom_i;
          end
        end
        StPerm: begin
          start_q <= 1'b0;
          if (p_done) begin
            hold_q <= p_state;
            st_q   <= (nx_q == NxSqueeze) ? StEmit : StNext;
            if (nx_q == NxSqueeze) begin
              dig_q <= p_state[63:0];
              lo_q  <= (left_q == CntW'(1));
            end
          end
        end
        StNext: begin
          unique case (nx_q)
            NxLen: begin
              st_q <= StPerm;
              start_q <= 1'b1;
              ld_word_q <= {52'd0, clen_sat, 3'b000};
              nx_q <= (phase_q == PhCustom && cust_q) ? NxMsg : NxPadThenMsg;
            end
            NxPadThenMsg: begin
              st_q <= StPerm;
              start_q <= 1'b1;
              ld_word_q <= 64'h1;
              phase_q <= PhMsg;
              nx_q <= NxMsg;
            end
            NxMsg: begin
              st_q <= StPerm;
              start_q <= 1'b1;
              if (!last_q || valid_q == 4'd8) ld_word_q <= word_q;
              else ld_word_q <= pad_word(word_q, valid_q);
              // A short last customization word ends without a squeeze.
              if (!last_q) nx_q <= NxDone;
              else if (valid_q == 4'd8) nx_q <= NxPad;
              else nx_q <= (phase_q == PhCustom) ? NxDone : NxSqueeze;
              if (phase_q == PhCustom && last_q) phase_q <= PhMsg;
              left_q <= nout;
              if (phase_q == PhCustom) fin_q <= 1'b0;
            end
            NxPad: begin
              st_q <= StPerm;
              start_q <= 1'b1;
              ld_word_q <= 64'h1;
              nx_q <= fin_q ? NxSqueeze : NxDone;
            end
            NxSqueeze: begin
              st_q <= StPerm;
              start_q <= 1'b1;
              ld_word_q <= '0;
            end
            default: begin
              start_q <= 1'b0;
              st_q <= StIdle;
              if (fin_q && phase_q == PhMsg) phase_q <= PhIdle;
            end
          endcase
        end
        StEmit: begin
          start_q <= !out_stall_i && (left_q != CntW'(1));
          if (!out_stall_i) begin
            left_q <= left_q - CntW'(1);
            if (left_q == CntW'(1)) begin
              st_q <= StIdle;
              phase_q <= PhIdle;
            end else begin
              ld_word_q <= '0;
              nx_q <= NxSqueeze;
              st_q <= StPerm;
            end
          end
        end
        default: begin
          st_q <= StIdle;
          start_q <= 1'b0;
        end
      endcase
    end
  end

  // A message last word that is not full goes straight to squeeze; the
  // done arm above returns to idle for the next item and sets the phase to
  // idle when that item ended the message.
  assign in_stall_o    = (st_q != StIdle);
  assign out_valid_o   = (st_q == StEmit);
  assign digest_word_o = dig_q;
  assign last_out_o    = lo_q;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_start |-> !p_busy) else $error("permutation restarted while busy");
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_q != '0) else $error("emit with no words left");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_out_o == (left_q == CntW'(1)))) else $error("last flag");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_ascon_hash_xof_engine_unit.sv]
// Self-checking testbench for the Ascon Hash256 / XOF128 / CXOF128 sponge engine.
`timescale 1ns / 1ps
module tb_ascon_hash_xof_engine_unit;

  // The digest store keeps its own copy of the sponge and the registers and
  // computes every squeeze word that an accepted input transfer should cause.
  class digest_board;
    typedef enum bit [1:0] {PhIdle, PhCustom, PhMsg} ph_e;
    bit [63:0] sponge [5];
    ph_e       phase;
    bit [1:0]  mode_r;
    bit [6:0]  outw_r;
    bit [8:0]  clen_r;
    bit [63:0] want_word [$];
    bit        want_last [$];
    int        errors;

    function void reset_state();
      foreach (sponge[k]) sponge[k] = '0;
      phase = PhIdle;
      mode_r = ahx_pkg::ModeHash;
      outw_r = 7'd4;
      clen_r = '0;
      want_word.delete();
      want_last.delete();
      errors = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [8:0] val);
      case (idx)
        ahx_pkg::RegMode:      mode_r = val[1:0];
        ahx_pkg::RegOutWords:  outw_r = val[6:0];
        ahx_pkg::RegCustomLen: clen_r = val;
        default: ;
      endcase
    endfunction

    static function bit [63:0] rotr(bit [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    // Twelve rounds: constant addition, substitution layer, linear layer.
    function void scramble();
      bit [63:0] a, b, c, d, e, ta, tb2, tc, td, te;
      {a, b, c, d, e} = {sponge[0], sponge[1], sponge[2], sponge[3], sponge[4]};
      for (int r = 0; r < 12; r++) begin
        c ^= 64'(8'hf0 - 8'(r * 16) + 8'(r));
        a ^= e; e ^= d; c ^= b;
        ta = ~a & b; tb2 = ~b & c; tc = ~c & d; td = ~d & e; te = ~e & a;
        a ^= tb2; b ^= tc; c ^= td; d ^= te; e ^= ta;
        b ^= a; a ^= e; d ^= c; c = ~c;
        a ^= rotr(a, 19) ^ rotr(a, 28);
        b ^= rotr(b, 61) ^ rotr(b, 39);
        c ^= rotr(c, 1) ^ rotr(c, 6);
        d ^= rotr(d, 10) ^ rotr(d, 17);
        e ^= rotr(e, 7) ^ rotr(e, 41);
      end
      {sponge[0], sponge[1], sponge[2], sponge[3], sponge[4]} = {a, b, c, d, e};
    endfunction

    function void take(bit [63:0] v);
      sponge[0] ^= v;
      scramble();
    endfunction

    // Final word of a phase, padded with 0x01 after the last valid byte; a full word gets the pad as an extra block.
    function void take_padded(bit [63:0] v, bit [3:0] nb);
      bit [63:0] keep;
      if (nb >= 8) begin
        take(v);
        take(64'h1);
      end else begin
        keep = (64'h1 << (8 * nb)) - 1;
        take((v & keep) | (64'h1 << (8 * nb)));
      end
    endfunction

    function void note_input(bit [63:0] w, bit [3:0] nb, bit last, bit cust);
      int n;
      if (phase == PhIdle) begin
        sponge[0] = (mode_r == ahx_pkg::ModeHash) ? ahx_pkg::IvHash :
                    (mode_r == ahx_pkg::ModeCxof) ? ahx_pkg::IvCxof : ahx_pkg::IvXof;
        for (int k = 1; k < 5; k++) sponge[k] = '0;
        scramble();
        if (mode_r == ahx_pkg::ModeCxof) begin
          take(64'((clen_r > 256 ? 256 : clen_r) * 8));
          phase = PhCustom;
        end else begin
          phase = PhMsg;
        end
      end
      if (phase == PhCustom) begin
        if (cust) begin
          if (last) begin
            take_padded(w, nb);
            phase = PhMsg;
          end else begin
            take(w);
          end
          return;
        end
        // Message word while the customization is still open.
        take(64'h1);
        phase = PhMsg;
      end
      if (!last) begin
        take(w);
        return;
      end
      take_padded(w, nb);
      n = (outw_r == 0) ? 1 : (outw_r > 64) ? 64 : outw_r;
      for (int k = 0; k < n; k++) begin
        want_word.push_back(sponge[0]);
        want_last.push_back(k == n - 1);
        scramble();
      end
      phase = PhIdle;
    endfunction

    function void check_result(bit [63:0] d, bit l);
      bit [63:0] ew;
      bit        el;
      if (want_word.size() == 0) begin
        $error("unexpected digest transfer: digest_word %h last_out %b", d, l);
        errors++;
        return;
      end
      ew = want_word.pop_front();
      el = want_last.pop_front();
      if (d !== ew) begin
        $error("digest_word: expected %h actual %h", ew, d);
        errors++;
      end
      if (l !== el) begin
        $error("last_out: expected %b actual %b", el, l);
        errors++;
      end
    endfunction

    function int pending();
      return want_word.size();
    endfunction
  endclass

  localparam int QuietLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_word_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        last_word_i = 1'b0;
  logic        is_custom_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] digest_word_o;
  logic        last_out_o;

  digest_board board;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          quiet;

  ascon_hash_xof_engine_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // The receiver stalls the output at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every accepted output transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(digest_word_o, last_out_o);
  end

  // Watchdog: the run ends if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("tb_ascon_hash_xof_engine_unit: FAIL");
        $finish;
      end
    end
  end

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_cfg(bit [1:0] idx, bit [8:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Withdraws the input, waits until every digest word is in, then lets the
  // engine settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic configure(bit [8:0] md, bit [8:0] ow, bit [8:0] cl);
    drain();
    write_cfg(ahx_pkg::RegMode, md);
    write_cfg(ahx_pkg::RegOutWords, ow);
    write_cfg(ahx_pkg::RegCustomLen, cl);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one input transfer and holds it until it is accepted.
  task automatic push(bit [63:0] w, bit [3:0] nb, bit last, bit cust);
    int gap;
    in_valid_i <= 1'b1;
    data_word_i <= w;
    valid_bytes_i <= nb;
    last_word_i <= last;
    is_custom_i <= cust;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(w, nb, last, cust);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Byte count for a last word: mostly 0..8, sometimes the values above 8.
  function automatic bit [3:0] rand_tail();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
  endfunction

  // One complete run: optional customization, then message words ending in a last word.
  task automatic random_run(bit noisy);
    int nc, nm;
    bit cx;
    cx = (board.mode_r == ahx_pkg::ModeCxof);
    if (cx) begin
      // Full customization, empty one, or a bare message word closing it.
      case ($urandom_range(0, 3))
        0: ;
        1: push(rand64(), 4'd0, 1'b1, 1'b1);
        default: begin
          nc = (board.clen_r > 32) ? $urandom_range(1, 3) : (board.clen_r + 7) / 8;
          if (nc == 0) nc = 1;
          for (int k = 0; k < nc - 1; k++)
            push(rand64(), noisy ? 4'($urandom) : 4'd8, 1'b0, 1'b1);
          push(rand64(), rand_tail(), 1'b1, 1'b1);
        end
      endcase
    end
    nm = $urandom_range(0, 3);
    for (int k = 0; k < nm; k++)
      push(rand64(), noisy ? 4'($urandom) : 4'd8, 1'b0, noisy && !cx ? 1'($urandom) : 1'b0);
    push(rand64(), rand_tail(), 1'b1, (noisy && !cx) ? 1'($urandom) : 1'b0);
  endtask

  task automatic set_pressure(int p);
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  initial begin
    int p;
    board = new();
    board.reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: reset defaults first, then the register extremes.
    set_pressure(0);
    push(64'h0, 4'd0, 1'b1, 1'b0);                       // empty message
    push(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0);        // full last word, extra pad block
    push(64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b0, 1'b1);        // ignored count and custom flag
    push(64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 1'b0);       // count above eight
    configure(ahx_pkg::ModeXof, 9'd1, 9'd0);
    push(64'h0123456789abcdef, 4'd3, 1'b1, 1'b0);
    configure(ahx_pkg::ModeCxof, 9'd64, 9'd0);
    push(64'h0, 4'd0, 1'b1, 1'b1);                       // empty customization word
    push(64'h55aa55aa55aa55aa, 4'd5, 1'b1, 1'b0);
    push(rand64(), 4'd8, 1'b1, 1'b0);                    // customization never sent
    configure(9'd3, 9'd0, 9'd511);                       // mode three, zero words
    push(rand64(), 4'd8, 1'b0, 1'b0);
    push(rand64(), 4'd1, 1'b1, 1'b1);
    configure(ahx_pkg::ModeCxof, 9'd127, 9'd256);        // saturating words, length at its limit
    for (int k = 0; k < 31; k++) push(rand64(), 4'd8, 1'b0, 1'b1);
    push(rand64(), 4'd8, 1'b1, 1'b1);
    push(rand64(), 4'd2, 1'b1, 1'b0);
    configure(ahx_pkg::ModeCxof, 9'd3, 9'd13);
    push(rand64(), 4'd8, 1'b0, 1'b1);
    push(rand64(), 4'd5, 1'b1, 1'b1);
    push(rand64(), 4'd8, 1'b0, 1'b0);
    push(rand64(), 4'd0, 1'b1, 1'b0);

    // Random part: a new register setting and idling pattern each phase.
    p = 0;
    while (items_sent < 230) begin
      configure(9'($urandom_range(0, 3)),
                ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511)) :
                                              9'($urandom_range(1, 8)),
                ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511)) :
                                              9'($urandom_range(0, 24)));
      set_pressure(p);
      for (int r = 0; r < 6; r++) random_run($urandom_range(0, 4) == 0);
      p++;
    end

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_ascon_hash_xof_engine_unit: PASS");
    end else begin
      $display("tb_ascon_hash_xof_engine_unit: FAIL");
    end
    $finish;
  end

endmodule
